// File: sv/rle7_pkg.sv
package rle7_pkg;

    localparam int CODE_W   = 8;
    localparam int GRAY_W   = 8;
    localparam int PIX_W    = 26;
    localparam int LEN_W    = 28;
    localparam int DIM_W    = 13;
    localparam int STATUS_W = 2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd3840;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd2400;
    localparam logic [PIX_W-1:0] FRAME_TOTAL_RST  = 26'd9216000;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd3;

    typedef enum logic [1:0] {
        K_SPAN  = 2'd0,
        K_BAD   = 2'd1,
        K_TRUNC = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [GRAY_W-1:0]  gray;
        logic [LEN_W-1:0]   want;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [GRAY_W-1:0]   gray;
        logic [PIX_W-1:0]    start_pixel;
        logic [PIX_W-1:0]    span_length;
        logic [STATUS_W-1:0] status;
        logic                layer_end;
    } t_result;

endpackage

// File: sv/rle7_fifo.sv
module rle7_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: sv/rle7_front.sv
module rle7_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [rle7_pkg::CODE_W-1:0]   i_code_byte,
    input  logic                          i_last,
    output logic                          o_cmd_valid,
    output rle7_pkg::t_cmd                o_cmd
);
    import rle7_pkg::*;

    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_LEN1 = 3'b010,
        PH_LENN = 3'b100
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [GRAY_W-1:0]   r_gray,  n_gray;
    logic [1:0]          r_left,  n_left;
    logic [LEN_W-1:0]    r_accum, n_accum;

    logic [GRAY_W-1:0]   code_gray;
    logic [1:0]          left_dec;
    logic [LEN_W-1:0]    accum_shift;

    assign code_gray   = {i_code_byte[6:0], 1'b1};
    assign left_dec    = r_left - 1'b1;
    assign accum_shift = {r_accum[LEN_W-9:0], i_code_byte};

    always_comb begin
        n_phase      = r_phase;
        n_gray       = r_gray;
        n_left       = r_left;
        n_accum      = r_accum;
        o_cmd_valid  = 1'b0;
        o_cmd.kind   = K_TRUNC;
        o_cmd.gray   = r_gray;
        o_cmd.want   = r_accum;
        o_cmd.last   = i_last;
        if (i_valid) begin
            unique case (r_phase)
                PH_CODE: begin
                    if (!i_code_byte[7]) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = K_SPAN;
                        o_cmd.gray  = code_gray;
                        o_cmd.want  = LEN_W'(1);
                    end else begin
                        n_gray      = code_gray;
                        n_phase     = PH_LEN1;
                        o_cmd_valid = i_last;
                        o_cmd.gray  = code_gray;
                    end
                end
                PH_LEN1: begin
                    if (!i_code_byte[7]) begin
                        n_accum     = LEN_W'(i_code_byte[6:0]);
                        n_left      = 2'd0;
                        n_phase     = PH_CODE;
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = K_SPAN;
                        o_cmd.want  = LEN_W'(i_code_byte[6:0]);
                    end else if (i_code_byte[7:6] == 2'b10) begin
                        n_accum     = LEN_W'(i_code_byte[5:0]);
                        n_left      = 2'd1;
                        n_phase     = PH_LENN;
                        o_cmd_valid = i_last;
                    end else if (i_code_byte[7:5] == 3'b110) begin
                        n_accum     = LEN_W'(i_code_byte[4:0]);
                        n_left      = 2'd2;
                        n_phase     = PH_LENN;
                        o_cmd_valid = i_last;
                    end else if (i_code_byte[7:4] == 4'b1110) begin
                        n_accum     = LEN_W'(i_code_byte[3:0]);
                        n_left      = 2'd3;
                        n_phase     = PH_LENN;
                        o_cmd_valid = i_last;
                    end else begin
                        n_phase     = PH_CODE;
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = K_BAD;
                    end
                end
                PH_LENN: begin
                    n_accum = accum_shift;
                    n_left  = left_dec;
                    if (left_dec == 2'd0) begin
                        n_phase     = PH_CODE;
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = K_SPAN;
                        o_cmd.want  = accum_shift;
                    end else begin
                        o_cmd_valid = i_last;
                    end
                end
                default: begin
                    n_phase = PH_CODE;
                end
            endcase
            // end of layer: start over
            if (i_last) begin
                n_phase = PH_CODE;
                n_gray  = '0;
                n_left  = '0;
                n_accum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_gray  <= '0;
            r_left  <= '0;
            r_accum <= '0;
        end else begin
            r_phase <= n_phase;
            r_gray  <= n_gray;
            r_left  <= n_left;
            r_accum <= n_accum;
        end
    end

endmodule

// File: sv/rle7_back.sv
module rle7_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rle7_pkg::PIX_W-1:0]   i_frame_total,
    input  logic                         i_cmd_valid,
    input  rle7_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    input  logic                         i_res_full,
    output logic                         o_res_push,
    output rle7_pkg::t_result            o_res
);
    import rle7_pkg::*;

    logic [PIX_W-1:0] r_pixel, n_pixel;
    logic             r_halted, n_halted;

    logic [PIX_W:0]   diff;
    logic [PIX_W-1:0] room;
    logic             too_long;

    assign diff     = {1'b0, i_frame_total} - {1'b0, r_pixel};
    assign room     = diff[PIX_W] ? '0 : diff[PIX_W-1:0];
    assign too_long = i_cmd.want > LEN_W'(room);
    assign o_cmd_pop = i_cmd_valid && !i_res_full;

    always_comb begin
        n_pixel           = r_pixel;
        n_halted          = r_halted;
        o_res_push        = 1'b0;
        o_res.gray        = i_cmd.gray;
        o_res.start_pixel = r_pixel;
        o_res.span_length = '0;
        o_res.status      = ST_OK;
        o_res.layer_end   = i_cmd.last;
        if (o_cmd_pop) begin
            if (r_halted) begin
                // drop everything but the layer's last beat
                o_res_push = i_cmd.last;
                o_res.gray = '0;
            end else begin
                unique case (i_cmd.kind)
                    K_SPAN: begin
                        o_res_push = 1'b1;
                        if (too_long) begin
                            n_halted          = 1'b1;
                            n_pixel           = r_pixel + room;
                            o_res.span_length = room;
                            o_res.status      = ST_OVERFLOW;
                        end else begin
                            n_pixel           = r_pixel + i_cmd.want[PIX_W-1:0];
                            o_res.span_length = i_cmd.want[PIX_W-1:0];
                        end
                    end
                    K_BAD: begin
                        o_res_push   = 1'b1;
                        n_halted     = 1'b1;
                        o_res.status = ST_BAD;
                    end
                    K_TRUNC: begin
                        o_res_push   = 1'b1;
                        o_res.status = ST_TRUNC;
                    end
                    default: begin
                        o_res_push = 1'b0;
                    end
                endcase
            end
            if (i_cmd.last) begin
                n_pixel  = '0;
                n_halted = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_pixel  <= n_pixel;
            r_halted <= n_halted;
        end
    end

endmodule

// File: sv/rle7_gray_layer_decoder.sv
// Path: a byte that causes a result pushes a command into the command queue at the
// accepting edge; the back end moves it into the result queue when that has room.
// Throughput: one byte per cycle if not full; one command per cycle if results not full.
// Reset (synchronous, active low) empties both queues, returns to the start of a
// layer and loads frame 3840 x 2400.
module rle7_gray_layer_decoder #(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [rle7_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [rle7_pkg::CODE_W-1:0]     i_code_byte,
    input  logic                            i_last,
    output logic                            empty,
    input  logic                            pop,
    output logic [rle7_pkg::GRAY_W-1:0]     o_gray,
    output logic [rle7_pkg::PIX_W-1:0]      o_start_pixel,
    output logic [rle7_pkg::PIX_W-1:0]      o_span_length,
    output logic [rle7_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_layer_end
);
    import rle7_pkg::*;

    logic [DIM_W-1:0] r_frame_width,  n_frame_width;
    logic [DIM_W-1:0] r_frame_height, n_frame_height;
    logic [PIX_W-1:0] r_frame_total,  n_frame_total;

    logic             in_accept;
    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd             cmd_in, cmd_out;
    logic [$bits(t_cmd)-1:0] cmd_bits;
    logic             res_push, res_full;
    t_result          res_in, res_out;
    logic [$bits(t_result)-1:0] res_bits;

    // frame size product tracks each register write
    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_frame_total  = r_frame_total;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    n_frame_width = i_cfg_data;
                    n_frame_total = PIX_W'(i_cfg_data) * PIX_W'(r_frame_height);
                end
                REG_FRAME_HEIGHT: begin
                    n_frame_height = i_cfg_data;
                    n_frame_total  = PIX_W'(r_frame_width) * PIX_W'(i_cfg_data);
                end
                default: begin
                    n_frame_total = r_frame_total;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_frame_total  <= FRAME_TOTAL_RST;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_frame_total  <= n_frame_total;
        end
    end

    assign full      = cmd_full;
    assign in_accept = push && !cmd_full;

    rle7_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_accept),
        .i_code_byte (i_code_byte),
        .i_last      (i_last),
        .o_cmd_valid (cmd_push),
        .o_cmd       (cmd_in)
    );

    rle7_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (cmd_empty)
    );

    assign cmd_out = t_cmd'(cmd_bits);

    rle7_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_total (r_frame_total),
        .i_cmd_valid   (!cmd_empty),
        .i_cmd         (cmd_out),
        .o_cmd_pop     (cmd_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_in)
    );

    rle7_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_bits);
    assign o_gray        = res_out.gray;
    assign o_start_pixel = res_out.start_pixel;
    assign o_span_length = res_out.span_length;
    assign o_status      = res_out.status;
    assign o_layer_end   = res_out.layer_end;

    a_res_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_last_always_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_last) |-> (cmd_push && cmd_in.last))
        else $error("last byte produced no command");

    a_trunc_ends_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_TRUNC) |-> o_layer_end)
        else $error("truncated run reported before layer end");

    a_bad_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_BAD || o_status == ST_TRUNC)) |-> (o_span_length == '0))
        else $error("error result carries pixels");

endmodule
